// ===== design/pqh_pkg.sv =====
// Shared constants, handshake structs and modular helpers for the palindrome
// hash block. No dependencies.
`timescale 1ns / 1ps

package pqh_pkg;

  // String geometry
  localparam int MAX_LENGTH = 4096;
  localparam int IDX_W      = $clog2(MAX_LENGTH + 1);  // one-based slot index
  localparam int PADDR_W    = $clog2(MAX_LENGTH);      // zero-based index
  localparam int LEN_W      = 13;                      // config and position fields
  localparam int CODE_W     = 5;

  // Hash arithmetic
  localparam int HASH_W    = 30;
  localparam int MUL_CNT_W = $clog2(HASH_W + 1);
  localparam int BASE_BITS = 10;
  localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
  localparam logic [HASH_W-1:0] HASH_BASE  = 30'd997;

  // Command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Multiplier request and response
  typedef struct packed {
    logic                 start;
    logic [HASH_W-1:0]    a;
    logic [HASH_W-1:0]    b;
    logic [MUL_CNT_W-1:0] nbits;
  } mm_req_t;

  typedef struct packed {
    logic              busy;
    logic [HASH_W-1:0] result;
  } mm_rsp_t;

  // (a + b) mod p, both operands already reduced
  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HASH_PRIME}) s = s - {1'b0, HASH_PRIME};
    return s[HASH_W-1:0];
  endfunction

  // (a - b) mod p, both operands already reduced
  function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + {1'b0, HASH_PRIME} - {1'b0, b};
    return s[HASH_W-1:0];
  endfunction

endpackage

// ===== design/pqh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pqh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pqh_modmul.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on pqh_pkg.
`timescale 1ns / 1ps

module pqh_modmul (
  input  logic            clk,
  input  logic            rst,
  input  pqh_pkg::mm_req_t req,
  output pqh_pkg::mm_rsp_t rsp
);

  logic [pqh_pkg::HASH_W-1:0]    acc;
  logic [pqh_pkg::HASH_W-1:0]    areg;
  logic [pqh_pkg::HASH_W-1:0]    breg;
  logic [pqh_pkg::MUL_CNT_W-1:0] cnt;
  logic [pqh_pkg::MUL_CNT_W-1:0] bit_idx;
  logic [pqh_pkg::HASH_W-1:0]    dbl;
  logic [pqh_pkg::HASH_W-1:0]    acc_next;

  // acc = 2*acc (+ a) mod p
  always_comb begin
    bit_idx  = cnt - 1'b1;
    dbl      = pqh_pkg::mod_add(acc, acc);
    acc_next = breg[bit_idx] ? pqh_pkg::mod_add(dbl, areg) : dbl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      acc  <= '0;
      areg <= req.a;
      breg <= req.b;
      cnt  <= req.nbits;
    end else if (cnt != '0) begin
      acc <= acc_next;
      cnt <= bit_idx;
    end
  end

  assign rsp.busy   = (cnt != '0);
  assign rsp.result = acc;

endmodule

// ===== design/palindrome_query_hash_fenwick_top.sv =====
// Palindrome query block: letter store, two Fenwick hash trees, power table.
// A set runs two 5-bit serial multiplies and climbs up to 13 tree levels; a query
// runs two prefix walks of up to 12 levels and two 30-bit serial multiplies, plus
// any wait on a stalled earlier result; a dropped item is accepted without a result.
// One item at a time. After rst a clearing pass fills the tables, no item
// accepted meanwhile. Depends on pqh_pkg.
`timescale 1ns / 1ps

module palindrome_query_hash_fenwick_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_enable,
  input  logic [pqh_pkg::LEN_W-1:0]   cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [pqh_pkg::LEN_W-1:0]   position,
  input  logic [pqh_pkg::CODE_W-1:0]  letter,
  input  logic [pqh_pkg::LEN_W-1:0]   left,
  input  logic [pqh_pkg::LEN_W-1:0]   right,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_mirror
);

  localparam int IW = pqh_pkg::IDX_W;
  localparam int PW = pqh_pkg::PADDR_W;
  localparam int HW = pqh_pkg::HASH_W;
  localparam int CW = pqh_pkg::CODE_W;

  typedef enum logic [18:0] {
    ST_CLR  = 19'h00001,
    ST_PWR  = 19'h00002,
    ST_PM   = 19'h00004,
    ST_IDLE = 19'h00008,
    ST_SRD  = 19'h00010,
    ST_SRD2 = 19'h00020,
    ST_SRD3 = 19'h00040,
    ST_SMF  = 19'h00080,
    ST_SMB  = 19'h00100,
    ST_STRD = 19'h00200,
    ST_STWR = 19'h00400,
    ST_QRD  = 19'h00800,
    ST_QAC  = 19'h01000,
    ST_QPW1 = 19'h02000,
    ST_QPW2 = 19'h04000,
    ST_QPW3 = 19'h08000,
    ST_QM1  = 19'h10000,
    ST_QM2  = 19'h20000,
    ST_QFIN = 19'h40000
  } state_t;

  state_t state;

  // Registers
  logic [pqh_pkg::LEN_W-1:0] string_length;
  logic [IW-1:0] caddr;
  logic [PW-1:0] pk;
  logic [HW-1:0] pval;
  logic [IW:0]   tidx;
  logic [PW-1:0] i0;
  logic [CW-1:0] code_r, oldc;
  logic [HW-1:0] wf, wb, dfwd, dbwd;
  logic [IW-1:0] fidx, bidx, lm1, m2_r, r_r;
  logic [HW-1:0] fsum, bsum, suma, sumb, h1, h2, pw1, pw2, prod1;
  logic          phase, same, ovalid, opal;

  // Memory ports
  logic          fwd_we, bwd_we, let_we, pow_we;
  logic [IW-1:0] fwd_waddr, fwd_raddr, bwd_raddr;
  logic [HW-1:0] fwd_wdata, bwd_wdata, fwd_rdata, bwd_rdata, pow_rdata;
  logic [PW-1:0] let_waddr, pow_waddr, pow_raddr;
  logic [CW-1:0] let_wdata, let_rdata;
  logic [HW-1:0] pow_wdata;

  pqh_pkg::mm_req_t mm_req;
  pqh_pkg::mm_rsp_t mm_rsp;

  // Derived values
  logic [IW-1:0] n;
  logic          set_ok, qry_ok;
  logic [IW:0]   sum_lr, sum_lr_m1, tidx_next;
  logic [IW-1:0] fidx_next, bidx_next;
  logic [HW-1:0] fsum_n, bsum_n, delta;
  logic [CW-1:0] d;
  logic          neg;

  // Active length: zero acts as one, clamp at the maximum
  always_comb begin
    if (string_length == '0)
      n = IW'(1);
    else if (IW'(string_length) > IW'(pqh_pkg::MAX_LENGTH))
      n = IW'(pqh_pkg::MAX_LENGTH);
    else
      n = IW'(string_length);
  end

  // Bounds checks and range midpoints
  always_comb begin
    set_ok    = (position != '0) && (IW'(position) <= n);
    qry_ok    = (left != '0) && (left <= right) && (IW'(right) <= n);
    sum_lr    = (IW+1)'(left) + (IW+1)'(right);
    sum_lr_m1 = sum_lr - 1'b1;
    tidx_next = tidx + (tidx & (~tidx + 1'b1));
    fidx_next = fidx & (fidx - 1'b1);
    bidx_next = bidx & (bidx - 1'b1);
    fsum_n    = (fidx != '0) ? pqh_pkg::mod_add(fsum, fwd_rdata) : fsum;
    bsum_n    = (bidx != '0) ? pqh_pkg::mod_add(bsum, bwd_rdata) : bsum;
    neg       = (code_r < oldc);
    d         = neg ? (oldc - code_r) : (code_r - oldc);
    delta     = neg ? pqh_pkg::mod_sub('0, mm_rsp.result) : mm_rsp.result;
  end

  // Shared multiplier requests
  always_comb begin
    mm_req = '0;
    unique case (state)
      ST_PWR: begin
        mm_req.start = (pk != PW'(pqh_pkg::MAX_LENGTH - 1));
        mm_req.a     = pval;
        mm_req.b     = pqh_pkg::HASH_BASE;
        mm_req.nbits = pqh_pkg::MUL_CNT_W'(pqh_pkg::BASE_BITS);
      end
      ST_SRD3: begin
        mm_req.start = 1'b1;
        mm_req.a     = wf;
        mm_req.b     = HW'(d);
        mm_req.nbits = pqh_pkg::MUL_CNT_W'(CW);
      end
      ST_SMF: begin
        mm_req.start = !mm_rsp.busy;
        mm_req.a     = wb;
        mm_req.b     = HW'(d);
        mm_req.nbits = pqh_pkg::MUL_CNT_W'(CW);
      end
      ST_QPW3: begin
        mm_req.start = 1'b1;
        mm_req.a     = h1;
        mm_req.b     = pw1;
        mm_req.nbits = pqh_pkg::MUL_CNT_W'(HW);
      end
      ST_QM1: begin
        mm_req.start = !mm_rsp.busy;
        mm_req.a     = h2;
        mm_req.b     = pw2;
        mm_req.nbits = pqh_pkg::MUL_CNT_W'(HW);
      end
      default: mm_req = '0;
    endcase
  end

  // Memory port muxing
  always_comb begin
    fwd_we    = 1'b0;
    bwd_we    = 1'b0;
    fwd_waddr = tidx[IW-1:0];
    fwd_wdata = pqh_pkg::mod_add(fwd_rdata, dfwd);
    bwd_wdata = pqh_pkg::mod_add(bwd_rdata, dbwd);
    fwd_raddr = (state == ST_STRD) ? tidx[IW-1:0] : fidx;
    bwd_raddr = (state == ST_STRD) ? tidx[IW-1:0] : bidx;
    let_we    = 1'b0;
    let_waddr = i0;
    let_wdata = code_r;
    pow_we    = (state == ST_PWR);
    pow_waddr = pk;
    pow_wdata = pval;
    if (state == ST_CLR) begin
      fwd_we    = 1'b1;
      bwd_we    = 1'b1;
      fwd_waddr = caddr;
      fwd_wdata = '0;
      bwd_wdata = '0;
      let_we    = (caddr < IW'(pqh_pkg::MAX_LENGTH));
      let_waddr = caddr[PW-1:0];
      let_wdata = '0;
    end else if (state == ST_STWR) begin
      fwd_we = 1'b1;
      bwd_we = 1'b1;
    end else if (state == ST_SRD3) begin
      let_we = 1'b1;
    end
    unique case (state)
      ST_SRD2: pow_raddr = PW'(n - IW'(i0) - 1'b1);
      ST_QPW1: pow_raddr = PW'(n - r_r);
      ST_QPW2: pow_raddr = lm1[PW-1:0];
      default: pow_raddr = i0;
    endcase
  end

  pqh_ram #(.WIDTH(HW), .DEPTH(pqh_pkg::MAX_LENGTH + 1)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(fwd_raddr), .rdata(fwd_rdata)
  );

  pqh_ram #(.WIDTH(HW), .DEPTH(pqh_pkg::MAX_LENGTH + 1)) u_bwd (
    .clk(clk), .we(bwd_we), .waddr(fwd_waddr), .wdata(bwd_wdata),
    .raddr(bwd_raddr), .rdata(bwd_rdata)
  );

  pqh_ram #(.WIDTH(CW), .DEPTH(pqh_pkg::MAX_LENGTH)) u_letters (
    .clk(clk), .we(let_we), .waddr(let_waddr), .wdata(let_wdata),
    .raddr(i0), .rdata(let_rdata)
  );

  pqh_ram #(.WIDTH(HW), .DEPTH(pqh_pkg::MAX_LENGTH)) u_pow (
    .clk(clk), .we(pow_we), .waddr(pow_waddr), .wdata(pow_wdata),
    .raddr(pow_raddr), .rdata(pow_rdata)
  );

  pqh_modmul u_mul (
    .clk(clk), .rst(rst), .req(mm_req), .rsp(mm_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLR;
      caddr         <= '0;
      pk            <= '0;
      pval          <= HW'(1);
      ovalid        <= 1'b0;
      string_length <= pqh_pkg::LEN_W'(1);
    end else begin
      if (cfg_write_enable) string_length <= cfg_write_data;
      // result leaves unless a new one takes its place this cycle
      if (ovalid && !out_stall && state != ST_QFIN) ovalid <= 1'b0;

      unique case (state)
        // clear trees and letters
        ST_CLR: begin
          caddr <= caddr + 1'b1;
          if (caddr == IW'(pqh_pkg::MAX_LENGTH)) begin
            state <= ST_PWR;
            pk    <= '0;
            pval  <= HW'(1);
          end
        end
        // power table fill
        ST_PWR: begin
          if (pk == PW'(pqh_pkg::MAX_LENGTH - 1)) state <= ST_IDLE;
          else                                   state <= ST_PM;
        end
        ST_PM: begin
          if (!mm_rsp.busy) begin
            pval  <= mm_rsp.result;
            pk    <= pk + 1'b1;
            state <= ST_PWR;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == pqh_pkg::CMD_SET) begin
              if (set_ok) begin
                i0     <= PW'(position - 1'b1);
                code_r <= letter;
                tidx   <= (IW+1)'(position);
                state  <= ST_SRD;
              end
            end else if (qry_ok) begin
              fidx  <= sum_lr[IW:1];
              bidx  <= IW'(right);
              lm1   <= IW'(left - 1'b1);
              m2_r  <= sum_lr_m1[IW:1];
              r_r   <= IW'(right);
              fsum  <= '0;
              bsum  <= '0;
              phase <= 1'b0;
              state <= ST_QRD;
            end
          end
        end
        // set: fetch old letter and weights
        ST_SRD:  state <= ST_SRD2;
        ST_SRD2: begin
          oldc  <= let_rdata;
          wf    <= pow_rdata;
          state <= ST_SRD3;
        end
        ST_SRD3: begin
          wb    <= pow_rdata;
          state <= ST_SMF;
        end
        ST_SMF: begin
          if (!mm_rsp.busy) begin
            dfwd  <= delta;
            state <= ST_SMB;
          end
        end
        ST_SMB: begin
          if (!mm_rsp.busy) begin
            dbwd  <= delta;
            state <= ST_STRD;
          end
        end
        // set: climb both trees
        ST_STRD: state <= ST_STWR;
        ST_STWR: begin
          tidx <= tidx_next;
          if (tidx_next > (IW+1)'(pqh_pkg::MAX_LENGTH)) state <= ST_IDLE;
          else                                         state <= ST_STRD;
        end
        // query: prefix walks
        ST_QRD: state <= ST_QAC;
        ST_QAC: begin
          fsum <= fsum_n;
          bsum <= bsum_n;
          fidx <= fidx_next;
          bidx <= bidx_next;
          if (fidx_next == '0 && bidx_next == '0) begin
            if (!phase) begin
              suma  <= fsum_n;
              sumb  <= bsum_n;
              fsum  <= '0;
              bsum  <= '0;
              fidx  <= lm1;
              bidx  <= m2_r;
              phase <= 1'b1;
              state <= ST_QRD;
            end else begin
              h1    <= pqh_pkg::mod_sub(suma, fsum_n);
              h2    <= pqh_pkg::mod_sub(sumb, bsum_n);
              state <= ST_QPW1;
            end
          end else begin
            state <= ST_QRD;
          end
        end
        // query: align and compare
        ST_QPW1: state <= ST_QPW2;
        ST_QPW2: begin
          pw1   <= pow_rdata;
          state <= ST_QPW3;
        end
        ST_QPW3: begin
          pw2   <= pow_rdata;
          state <= ST_QM1;
        end
        ST_QM1: begin
          if (!mm_rsp.busy) begin
            prod1 <= mm_rsp.result;
            state <= ST_QM2;
          end
        end
        ST_QM2: begin
          if (!mm_rsp.busy) begin
            same  <= (mm_rsp.result == prod1);
            state <= ST_QFIN;
          end
        end
        ST_QFIN: begin
          if (!ovalid || !out_stall) begin
            ovalid <= 1'b1;
            opal   <= same;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_CLR;
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = ovalid;
  assign is_mirror = opal;

  // Checks
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_QFIN))
    else $error("result without a finished query");

  a_mul_not_busy: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_tree_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STWR) |-> (tidx != '0))
    else $error("tree write at slot zero");

  a_set_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && cmd == pqh_pkg::CMD_SET && set_ok)
      |=> (state == ST_SRD))
    else $error("valid set not started");

endmodule

// ===== test/tb_palindrome_query_hash_fenwick_top.sv =====
// Self-checking testbench for palindrome_query_hash_fenwick_top: drives set and query
// transfers and predicts each palindrome verdict with its own Fenwick hash model.
// Depends on pqh_pkg and the design top.
`timescale 1ns / 1ps

module tb_palindrome_query_hash_fenwick_top;

  localparam longint unsigned PRIME = 64'd1000000007;
  localparam int unsigned STRING_MAX = 4096;
  localparam int WATCHDOG_LIMIT = 250000;  // covers the clearing pass after reset
  localparam int DRAIN_CYCLES = 200;       // longest item plus margin
  localparam int FWD = 0;
  localparam int BWD = 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic [pqh_pkg::LEN_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = pqh_pkg::CMD_SET;
  logic [pqh_pkg::LEN_W-1:0] position = '0;
  logic [pqh_pkg::CODE_W-1:0] letter = '0;
  logic [pqh_pkg::LEN_W-1:0] left = '0;
  logic [pqh_pkg::LEN_W-1:0] right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_mirror;

  palindrome_query_hash_fenwick_top DUT (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .position(position), .letter(letter), .left(left), .right(right),
    .out_valid(out_valid), .out_stall(out_stall), .is_mirror(is_mirror)
  );

  always #6 clk = ~clk;

  // Shadow state of the block
  int unsigned hash_tree[2][0:STRING_MAX];
  int unsigned letter_store[0:STRING_MAX-1];
  int unsigned base_power[0:STRING_MAX-1];
  int unsigned length_reg;
  bit verdict_queue[$];

  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic int unsigned hadd(int unsigned a, int unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s >= PRIME) ? int'(s - PRIME) : int'(s);
  endfunction

  function automatic int unsigned hneg(int unsigned a);
    return (a == 0) ? 0 : int'(PRIME - a);
  endfunction

  function automatic int unsigned hmul(int unsigned a, int unsigned b);
    return int'((longint'(a) * longint'(b)) % PRIME);
  endfunction

  function automatic void tree_bump(int w, int unsigned idx, int unsigned delta);
    while (idx >= 1 && idx <= STRING_MAX) begin
      hash_tree[w][idx] = hadd(hash_tree[w][idx], delta);
      idx += idx & (~idx + 1);
    end
  endfunction

  function automatic int unsigned tree_prefix(int w, int unsigned idx);
    int unsigned sum;
    sum = 0;
    if (idx > STRING_MAX) idx = STRING_MAX;
    while (idx > 0) begin
      sum = hadd(sum, hash_tree[w][idx]);
      idx -= idx & (~idx + 1);
    end
    return sum;
  endfunction

  function automatic int unsigned eff_length();
    if (length_reg == 0) return 1;
    if (length_reg > STRING_MAX) return STRING_MAX;
    return length_reg;
  endfunction

  // Apply one accepted transfer to the shadow state; queue a verdict for a valid query
  function automatic void predict_palindrome_item(logic c, int unsigned pos, int unsigned code,
                                                  int unsigned l, int unsigned r);
    int unsigned n, i0, wf, wb, oldc, h1, h2;
    n = eff_length();
    if (c == pqh_pkg::CMD_SET) begin
      if (pos == 0 || pos > n) return;
      i0 = pos - 1;
      wf = base_power[i0];
      wb = base_power[n - 1 - i0];
      oldc = letter_store[i0];
      tree_bump(FWD, pos, hneg(hmul(oldc, wf)));
      tree_bump(FWD, pos, hmul(code, wf));
      tree_bump(BWD, pos, hneg(hmul(oldc, wb)));
      tree_bump(BWD, pos, hmul(code, wb));
      letter_store[i0] = code;
    end else begin
      if (l == 0 || l > r || r > n) return;
      h1 = hadd(tree_prefix(FWD, (l + r) / 2), hneg(tree_prefix(FWD, l - 1)));
      h2 = hadd(tree_prefix(BWD, r), hneg(tree_prefix(BWD, (l + r - 1) / 2)));
      verdict_queue.push_back(hmul(h1, base_power[n - r]) == hmul(h2, base_power[l - 1]));
    end
  endfunction

  // One transfer on the input channel; sender works in bursts with random gaps
  task automatic send_item(logic c, int unsigned pos, int unsigned code,
                           int unsigned l, int unsigned r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    position <= pos[pqh_pkg::LEN_W-1:0];
    letter <= code[pqh_pkg::CODE_W-1:0];
    left <= l[pqh_pkg::LEN_W-1:0];
    right <= r[pqh_pkg::LEN_W-1:0];
    do @(posedge clk); while (in_stall);
    predict_palindrome_item(c, pos & 13'h1FFF, code & 5'h1F, l & 13'h1FFF, r & 13'h1FFF);
    items_sent++;
  endtask

  task automatic set_letter(int unsigned pos, int unsigned code);
    send_item(pqh_pkg::CMD_SET, pos, code, $urandom_range(8191), $urandom_range(8191));
  endtask

  task automatic query_range(int unsigned l, int unsigned r);
    send_item(pqh_pkg::CMD_QUERY, $urandom_range(8191), $urandom_range(31), l, r);
  endtask

  // Length change only once the block has drained
  task automatic write_length(int unsigned value);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= value[pqh_pkg::LEN_W-1:0];
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    length_reg = value & 13'h1FFF;
  endtask

  // Result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %0b", is_mirror);
      end else begin
        if (is_mirror !== verdict_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected %0b got %0b", verdict_queue[0], is_mirror);
        end
        void'(verdict_queue.pop_front());
      end
    end
  end

  // Receiver stall pattern: a random mode, redrawn whenever its countdown runs out
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(3);
      stall_count <= $urandom_range(500, 64);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 25);
      2: out_stall <= ($urandom_range(99) < 75);
      default: out_stall <= stall_count[4];
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("palindrome_query_hash_fenwick_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Default length 1, bad bounds, then sets and a query
  task automatic test_after_reset();
    query_range(1, 1);
    query_range(0, 0);
    query_range(2, 2);
    query_range(1, 0);
    set_letter(1, 26);
    set_letter(2, 5);
    query_range(1, 1);
  endtask

  // Length extremes, odd letter codes, bad positions
  task automatic test_directed();
    write_length(0);
    set_letter(1, 0);
    query_range(1, 1);
    write_length(8191);
    set_letter(4096, 31);
    set_letter(1, 27);
    set_letter(0, 3);
    set_letter(8191, 3);
    query_range(1, 4096);
    query_range(4096, 4096);
    query_range(1, 8191);
    write_length(4096);
    set_letter(4095, 31);
    query_range(4095, 4096);
    write_length(5);
    set_letter(1, 1); set_letter(2, 2); set_letter(3, 3); set_letter(4, 2); set_letter(5, 1);
    set_letter(6, 9);
    query_range(1, 5);
    query_range(2, 4);
    query_range(1, 4);
    query_range(3, 2);
  endtask

  // Load strings, mostly mirrored, then query; some noise transfers
  task automatic test_random_phases();
    int unsigned n, k, l, r, code;
    int unsigned text[0:STRING_MAX-1];
    int phase;
    phase = 0;
    while (items_sent < 2050) begin
      phase++;
      if (phase % 9 == 0) n = ($urandom_range(1) == 0) ? 4096 : 8191;
      else if (phase % 4 == 0) n = $urandom_range(300, 41);
      else n = $urandom_range(40, 0);
      write_length(n);
      n = eff_length();
      if (n > 300) begin
        // Sparse load of a long string
        repeat (40) set_letter($urandom_range(n, 1), $urandom_range(31));
        repeat (30) begin
          l = $urandom_range(n, n - 50);
          query_range(l, $urandom_range(n, l));
        end
        query_range(1, n);
        continue;
      end
      for (k = 0; k < n; k++)
        text[k] = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(3, 1);
      if ($urandom_range(3) != 0)
        for (k = 0; k < n / 2; k++)
          text[n - 1 - k] = text[k];
      for (k = 0; k < n; k++) set_letter(k + 1, text[k]);
      repeat (n + 10) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            l = $urandom_range((n + 1) / 2, 1);
            query_range(l, n + 1 - l);
          end
          4, 5: begin
            l = $urandom_range(n, 1);
            query_range(l, $urandom_range(n, l));
          end
          6: begin
            k = $urandom_range(n, 1);
            code = $urandom_range(3, 1);
            set_letter(k, code);
            if ($urandom_range(1) == 0) set_letter(n + 1 - k, code);
          end
          7: set_letter($urandom_range(8191), $urandom_range(31));
          8: query_range($urandom_range(8191), $urandom_range(8191));
          default: query_range($urandom_range(n + 2), $urandom_range(n + 2));
        endcase
      end
    end
  endtask

  initial begin
    int unsigned k;
    base_power[0] = 1;
    for (k = 1; k < STRING_MAX; k++) base_power[k] = hmul(base_power[k - 1], 997);
    for (k = 0; k <= STRING_MAX; k++) begin
      hash_tree[FWD][k] = 0;
      hash_tree[BWD][k] = 0;
    end
    for (k = 0; k < STRING_MAX; k++) letter_store[k] = 0;
    length_reg = 1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    test_after_reset();
    test_directed();
    test_random_phases();

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_queue.size() == 0)
      $display("palindrome_query_hash_fenwick_top regression: pass");
    else
      $display("palindrome_query_hash_fenwick_top regression: fail");
    $finish;
  end

endmodule
